// File: sv/svt_pkg.sv
// shared types, constants and sine table function for the steering vector tone generator
package svt_pkg;

   localparam int PHASE_W   = 32;
   localparam int IDX_W     = 6;
   localparam int SAMPLE_W  = 16;
   localparam int MAG_W     = 15;
   localparam int START_W   = 48;
   localparam int STEP_W    = 40;
   localparam int COUNT_W   = 7;
   localparam int FREQ_W    = 32;
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STEPS  = 2'd2;

   localparam logic [START_W-1:0] START_TIME_RESET = 48'd0;
   localparam logic [STEP_W-1:0]  TIME_STEP_RESET  = 40'd1;
   localparam logic [COUNT_W-1:0] NUM_STEPS_RESET  = 7'd64;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [PHASE_W-1:0] inc;
      logic [IDX_W-1:0]   last_idx;
      logic               fin;
   } job_type;

   // quarter-wave sine entry, taylor series in q30 with truncation at each step
   function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned abits);
      longint unsigned x;
      longint unsigned term;
      longint unsigned r;
      longint          sum;
      x = (HALF_PI_Q30 * 64'(k)) >> abits;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= 9; i++) begin
         term = (((term * x) >> 30) * x) >> 30;
         unique case (i)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            7: term = term / 64'd210;
            8: term = term / 64'd272;
            default: term = term / 64'd342;
         endcase
         if ((i & 1) != 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (longint'(unsigned'(sum)) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[MAG_W-1:0];
   endfunction

endpackage

// File: sv/steering_vector_tone_generator.sv
// top level: config registers, front end, job queue and back end of the tone generator
// path: front multiply pipeline, job queue, sample sequencer, table stages, output register
// throughput: a sample per cycle unless stalled; rows of max(num_steps, 1) samples, up to MAX_STEPS
// front multiply pipeline takes a frequency every cycle unless stalled; the sequencer sets the rate
// reset: synchronous, active high; clears all valid state and returns registers to reset values
module steering_vector_tone_generator #(
   parameter int MAX_STEPS      = 64,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // frequency
   input  logic                            req_tlast,   // final_frequency
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // real_part, imag_part, sample_index
   output logic                            rsp_tlast,   // last_in_row
   output logic                            rsp_tuser,   // end_of_matrix
   input  logic                            csr_we,
   input  logic [svt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [svt_pkg::CSR_W-1:0]       csr_wdata
);
   import svt_pkg::*;

   logic [START_W-1:0] start_time_ff;
   logic [STEP_W-1:0]  time_step_ff;
   logic [COUNT_W-1:0] num_steps_ff;

   logic f_valid, f_ready;
   job_type f_job;
   logic q_valid, q_ready;
   job_type q_job;

   logic [SAMPLE_W-1:0] rsp_real, rsp_imag;
   logic [IDX_W-1:0] rsp_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= START_TIME_RESET;
         time_step_ff  <= TIME_STEP_RESET;
         num_steps_ff  <= NUM_STEPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_TIME: start_time_ff <= csr_wdata[START_W-1:0];
            CSR_TIME_STEP:  time_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_NUM_STEPS:  num_steps_ff  <= csr_wdata[COUNT_W-1:0];
            default:        ;
         endcase
      end
   end

   svt_front #(
      .MAX_STEPS(MAX_STEPS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_frequency (req_tdata),
      .in_final     (req_tlast),
      .start_time   (start_time_ff),
      .time_step    (time_step_ff),
      .num_steps    (num_steps_ff),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_job      (f_job)
   );

   svt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_job    (f_job),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_job   (q_job)
   );

   svt_back #(
      .SINE_ADDR_BITS(SINE_ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job       (q_job),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_real  (rsp_real),
      .rsp_imag  (rsp_imag),
      .rsp_index (rsp_index),
      .rsp_last  (rsp_tlast),
      .rsp_eom   (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, rsp_index, rsp_imag, rsp_real};

endmodule

// File: sv/svt_front.sv
// front end: accepts frequencies, forms start phase and increment in a multiply pipeline
module svt_front #(
   parameter int MAX_STEPS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [svt_pkg::FREQ_W-1:0]    in_frequency,
   input  logic                          in_final,
   input  logic [svt_pkg::START_W-1:0]   start_time,
   input  logic [svt_pkg::STEP_W-1:0]    time_step,
   input  logic [svt_pkg::COUNT_W-1:0]   num_steps,
   output logic                          out_valid,
   input  logic                          out_ready,
   output svt_pkg::job_type              out_job
);
   import svt_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_STEPS);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic signed [FREQ_W-1:0] f1_ff, f2_ff, f3_ff;
   logic [START_W-1:0] start1_ff, start2_ff, start3_ff, start4_ff;
   logic [START_W-1:0] start1_in, start2_in;
   logic [START_W-1:0] inc3_ff, inc4_ff, inc3_in, inc4_in;
   logic [IDX_W-1:0] last1_ff, last2_ff, last3_ff, last4_ff;
   logic fin1_ff, fin2_ff, fin3_ff, fin4_ff;

   logic [COUNT_W-1:0] cnt;
   logic [COUNT_W-1:0] cnt_m1;
   logic signed [56:0] mul1, mul2;
   logic signed [52:0] mul3, mul4;

   assign rdy4 = !v4_ff || out_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      priority if (num_steps == '0) begin
         cnt = COUNT_W'(1);
      end else if (num_steps > MAX_CNT) begin
         cnt = MAX_CNT;
      end else begin
         cnt = num_steps;
      end
   end
   assign cnt_m1 = cnt - COUNT_W'(1);

   assign mul1 = $signed(in_frequency) * $signed({1'b0, start_time[23:0]});
   assign start1_in = mul1[47:0];
   assign mul2 = f1_ff * $signed({1'b0, start_time[47:24]});
   assign start2_in = start1_ff + {mul2[23:0], 24'b0};
   assign mul3 = f2_ff * $signed({1'b0, time_step[19:0]});
   assign inc3_in = mul3[47:0];
   assign mul4 = f3_ff * $signed({1'b0, time_step[39:20]});
   assign inc4_in = inc3_ff + {mul4[27:0], 20'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         f1_ff     <= $signed(in_frequency);
         start1_ff <= start1_in;
         last1_ff  <= cnt_m1[IDX_W-1:0];
         fin1_ff   <= in_final;
      end
      if (rdy2) begin
         f2_ff     <= f1_ff;
         start2_ff <= start2_in;
         last2_ff  <= last1_ff;
         fin2_ff   <= fin1_ff;
      end
      if (rdy3) begin
         f3_ff     <= f2_ff;
         start3_ff <= start2_ff;
         inc3_ff   <= inc3_in;
         last3_ff  <= last2_ff;
         fin3_ff   <= fin2_ff;
      end
      if (rdy4) begin
         start4_ff <= start3_ff;
         inc4_ff   <= inc4_in;
         last4_ff  <= last3_ff;
         fin4_ff   <= fin3_ff;
      end
   end

   assign out_valid        = v4_ff;
   assign out_job.phase    = start4_ff[47:16];
   assign out_job.inc      = inc4_ff[47:16];
   assign out_job.last_idx = last4_ff;
   assign out_job.fin      = fin4_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> v1_ff)
      else $error("accepted frequency did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !out_ready) |=> (v4_ff && $stable(inc4_ff) && $stable(start4_ff)))
      else $error("stalled job changed in the front pipeline");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy3) |=> v3_ff)
      else $error("stage lost its job while stalled");

endmodule

// File: sv/svt_queue.sv
// short job queue between front and back end
module svt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  svt_pkg::job_type  in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output svt_pkg::job_type  out_job
);
   import svt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic push, pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_job = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count missed a push");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

// File: sv/svt_back.sv
// back end: sample sequencer, quarter-wave table lookup and output register
module svt_back #(
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   output logic                           job_ready,
   input  svt_pkg::job_type               job,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [svt_pkg::SAMPLE_W-1:0]   rsp_real,
   output logic [svt_pkg::SAMPLE_W-1:0]   rsp_imag,
   output logic [svt_pkg::IDX_W-1:0]      rsp_index,
   output logic                           rsp_last,
   output logic                           rsp_eom
);
   import svt_pkg::*;

   localparam int A_W = SINE_ADDR_BITS + 1;
   localparam int TAB_DEPTH = (1 << SINE_ADDR_BITS) + 1;
   localparam logic [A_W-1:0] FULL = A_W'(1 << SINE_ADDR_BITS);

   logic [MAG_W-1:0] sine_tab [TAB_DEPTH];

   for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_tab
      assign sine_tab[k] = quarter_sine(k, SINE_ADDR_BITS);
   end

   logic en;
   logic take;
   logic at_last;

   logic active_ff;
   logic [PHASE_W-1:0] phase_ff, inc_ff;
   logic [IDX_W-1:0] n_ff, last_ff;
   logic fin_ff;

   logic [SINE_ADDR_BITS+1:0] p;
   logic [1:0] quad;
   logic [A_W-1:0] idx, idx_mirror;

   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic [A_W-1:0] s1_sin_addr_ff, s1_cos_addr_ff;
   logic s1_sin_neg_ff, s1_cos_neg_ff, s2_sin_neg_ff, s2_cos_neg_ff;
   logic [IDX_W-1:0] s1_n_ff, s2_n_ff, out_n_ff;
   logic s1_last_ff, s2_last_ff, out_last_ff;
   logic s1_eom_ff, s2_eom_ff, out_eom_ff;
   logic [MAG_W-1:0] s2_sin_ff, s2_cos_ff;
   logic [SAMPLE_W-1:0] out_real_ff, out_imag_ff;
   logic [SAMPLE_W-1:0] real_in, imag_in;

   assign en = !out_valid_ff || rsp_ready;
   assign at_last = n_ff == last_ff;
   assign take = en && (!active_ff || at_last);
   assign job_ready = take;

   assign p = phase_ff[PHASE_W-1 -: SINE_ADDR_BITS + 2];
   assign quad = p[SINE_ADDR_BITS+1:SINE_ADDR_BITS];
   assign idx = {1'b0, p[SINE_ADDR_BITS-1:0]};
   assign idx_mirror = FULL - idx;

   assign real_in = s2_cos_neg_ff ? -{1'b0, s2_cos_ff} : {1'b0, s2_cos_ff};
   assign imag_in = s2_sin_neg_ff ? -{1'b0, s2_sin_ff} : {1'b0, s2_sin_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         if (take) begin
            active_ff <= job_valid;
         end
         s1_valid_ff  <= active_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (take) begin
            phase_ff <= job.phase;
            inc_ff   <= job.inc;
            n_ff     <= '0;
            last_ff  <= job.last_idx;
            fin_ff   <= job.fin;
         end else begin
            phase_ff <= phase_ff + inc_ff;
            n_ff     <= n_ff + IDX_W'(1);
         end
         s1_sin_addr_ff <= quad[0] ? idx_mirror : idx;
         s1_sin_neg_ff  <= quad[1];
         s1_cos_addr_ff <= quad[0] ? idx : idx_mirror;
         s1_cos_neg_ff  <= quad[0] ^ quad[1];
         s1_n_ff        <= n_ff;
         s1_last_ff     <= at_last;
         s1_eom_ff      <= at_last && fin_ff;
         s2_sin_ff      <= sine_tab[s1_sin_addr_ff];
         s2_cos_ff      <= sine_tab[s1_cos_addr_ff];
         s2_sin_neg_ff  <= s1_sin_neg_ff;
         s2_cos_neg_ff  <= s1_cos_neg_ff;
         s2_n_ff        <= s1_n_ff;
         s2_last_ff     <= s1_last_ff;
         s2_eom_ff      <= s1_eom_ff;
         out_real_ff    <= real_in;
         out_imag_ff    <= imag_in;
         out_n_ff       <= s2_n_ff;
         out_last_ff    <= s2_last_ff;
         out_eom_ff     <= s2_eom_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_real  = out_real_ff;
   assign rsp_imag  = out_imag_ff;
   assign rsp_index = out_n_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_eom   = out_eom_ff;

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (en && active_ff && !at_last) |=> (n_ff == $past(n_ff) + IDX_W'(1)))
      else $error("sample index did not advance");

   a_eom_on_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_eom_ff) |-> out_last_ff)
      else $error("end of matrix without end of row");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (n_ff <= last_ff))
      else $error("sample index past end of row");

endmodule
